@@ sv/mbp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared constants and types for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int unsigned ELEM_W         = 32;   // element_value width
  localparam int unsigned OUT_W          = 32;   // packed_word width
  localparam int unsigned CFG_W          = 6;    // element_width register width
  localparam int unsigned WORD_WIDTH_DEF = 32;   // default packing word size

  localparam logic [CFG_W-1:0] ELEM_WIDTH_RST = 6'd8;

  // Up to two words leave the packer per element; word0 always comes first.
  typedef struct packed {
    logic             valid0;
    logic [OUT_W-1:0] word0;
    logic             last0;
    logic             valid1;
    logic [OUT_W-1:0] word1;
    logic             last1;
  } pack_res_t;

endpackage
`default_nettype wire

@@ sv/mbp_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_elem_if / mbp_word_if
// Valid/ready channels for input elements and packed output words.
// ----------------------------------------------------------------------------
interface mbp_elem_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_value;
  logic        last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface mbp_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic        last_word;

  modport source (output valid, output packed_word, output last_word, input ready);
  modport sink   (input valid, input packed_word, input last_word, output ready);
endinterface
`default_nettype wire

@@ sv/msb_first_bit_packer_core.sv @@
`default_nettype none
// Path: an accepted element is held in the input register, then shifted and
//   merged into the output queue, from which its words leave.
// Throughput: one element per cycle while the output queue has room; output
//   runs at one word per cycle while words.ready is high.
// Reset: rst (sync, active high) empties the packer and queue, width -> 8.
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// Packs variable-width elements MSB first, gap-free, into 32-bit words.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core #(
  parameter int unsigned WORD_WIDTH = mbp_pkg::WORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mbp_pkg::CFG_W-1:0]   cfg_wdata,
  mbp_elem_if.sink                    elements,
  mbp_word_if.source                  words
);
  import mbp_pkg::*;

  // element_width register; the user must write it only while idle (not enforced)
  logic [CFG_W-1:0]  element_width;

  // input register stage
  logic              s1_valid;
  logic [ELEM_W-1:0] s1_value;
  logic              s1_last;
  logic              take;
  logic              room;
  pack_res_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_width <= ELEM_WIDTH_RST;
    end else if (cfg_we) begin
      element_width <= cfg_wdata;
    end
  end

  // Element moves into the packer only when the queue can absorb two words.
  assign take           = s1_valid && room;
  assign elements.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (elements.ready) begin
      s1_valid <= elements.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (elements.valid && elements.ready) begin
      s1_value <= elements.element_value;
      s1_last  <= elements.last_element;
    end
  end

  mbp_pack_unit #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_pack (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .value         (s1_value),
    .last          (s1_last),
    .element_width (element_width),
    .res           (res)
  );

  mbp_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .res   (res),
    .room  (room),
    .words (words)
  );

endmodule
`default_nettype wire

@@ sv/mbp_pack_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pack_unit
// Accumulator and shift/merge logic: one element in, zero to two words out.
// ----------------------------------------------------------------------------
module mbp_pack_unit #(
  parameter int unsigned WORD_WIDTH = mbp_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [mbp_pkg::ELEM_W-1:0]   value,
  input  logic                         last,
  input  logic [mbp_pkg::CFG_W-1:0]    element_width,
  output mbp_pkg::pack_res_t           res
);
  import mbp_pkg::*;

  localparam int unsigned FW    = $clog2(WORD_WIDTH + 1);
  localparam int unsigned TOT_W = $clog2(WORD_WIDTH + 33);
  localparam int unsigned XW    = WORD_WIDTH + 32;
  localparam int unsigned CAP   = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

  logic [WORD_WIDTH-1:0] accumulator, accumulator_next;
  logic [FW-1:0]         fill_bits, fill_bits_next;

  logic [CFG_W-1:0]      w_eff;
  logic [ELEM_W-1:0]     v_mask;
  logic [XW-1:0]         vx;
  logic [TOT_W-1:0]      total, over, shift_fit, shift_rem;
  logic [XW-1:0]         fit_x, hi_x, rem_x;
  logic [WORD_WIDTH-1:0] merged, full_ovf, rem_word;

  function automatic logic [OUT_W-1:0] to_out(input logic [WORD_WIDTH-1:0] wd);
    logic [XW-1:0] t;
    t = XW'(wd);
    return t[OUT_W-1:0];
  endfunction

  // saturate width to 1..CAP
  always_comb begin
    if (element_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (element_width > CFG_W'(CAP)) begin
      w_eff = CFG_W'(CAP);
    end else begin
      w_eff = element_width;
    end
  end

  assign v_mask    = value & (32'hFFFF_FFFF >> (CFG_W'(32) - w_eff));
  assign vx        = XW'(v_mask);
  assign total     = TOT_W'(fill_bits) + TOT_W'(w_eff);
  assign over      = total - TOT_W'(WORD_WIDTH);
  assign shift_fit = TOT_W'(WORD_WIDTH) - total;
  assign shift_rem = TOT_W'(WORD_WIDTH) - over;
  assign fit_x     = vx << shift_fit;
  assign hi_x      = vx >> over;
  assign rem_x     = vx << shift_rem;
  assign merged    = accumulator | fit_x[WORD_WIDTH-1:0];
  assign full_ovf  = accumulator | hi_x[WORD_WIDTH-1:0];
  assign rem_word  = rem_x[WORD_WIDTH-1:0];

  always_comb begin
    res              = '0;
    accumulator_next = accumulator;
    fill_bits_next   = fill_bits;
    if (total <= TOT_W'(WORD_WIDTH)) begin
      if (total == TOT_W'(WORD_WIDTH)) begin
        res.valid0       = 1'b1;
        res.word0        = to_out(merged);
        res.last0        = last;
        accumulator_next = '0;
        fill_bits_next   = '0;
      end else begin
        accumulator_next = merged;
        fill_bits_next   = FW'(total);
      end
    end else begin
      // overflow: full word out, low leftover bits open the next word
      res.valid0       = 1'b1;
      res.word0        = to_out(full_ovf);
      res.last0        = 1'b0;
      accumulator_next = rem_word;
      fill_bits_next   = FW'(over);
    end
    if (last) begin
      if (fill_bits_next != '0) begin
        if (res.valid0) begin
          res.valid1 = 1'b1;
          res.word1  = to_out(accumulator_next);
          res.last1  = 1'b1;
        end else begin
          res.valid0 = 1'b1;
          res.word0  = to_out(accumulator_next);
          res.last0  = 1'b1;
        end
      end
      accumulator_next = '0;
      fill_bits_next   = '0;
    end
    if (!take) begin
      res.valid0 = 1'b0;
      res.valid1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      fill_bits   <= '0;
    end else if (take) begin
      accumulator <= accumulator_next;
      fill_bits   <= fill_bits_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/mbp_out_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_out_queue
// Three-entry shifting word queue; takes up to two words per cycle.
// ----------------------------------------------------------------------------
module mbp_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  mbp_pkg::pack_res_t   res,
  output logic                 room,
  mbp_word_if.source           words
);
  import mbp_pkg::*;

  localparam int unsigned DEPTH = 3;

  logic [OUT_W-1:0] q_word [DEPTH];
  logic             q_last [DEPTH];
  logic [OUT_W-1:0] q_word_next [DEPTH];
  logic             q_last_next [DEPTH];
  logic [1:0]       count, count_next, base;
  logic             pop;

  assign pop           = words.valid && words.ready;
  assign room          = (count < 2'd2);
  assign words.valid   = (count != 2'd0);
  assign words.packed_word = q_word[0];
  assign words.last_word   = q_last[0];

  assign base       = count - 2'(pop);
  assign count_next = 2'(base + 2'(res.valid0) + 2'(res.valid1));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        q_word_next[i] = q_word[(i + 1) % DEPTH];
        q_last_next[i] = q_last[(i + 1) % DEPTH];
      end else begin
        q_word_next[i] = q_word[i];
        q_last_next[i] = q_last[i];
      end
      if (res.valid0 && (base == 2'(i))) begin
        q_word_next[i] = res.word0;
        q_last_next[i] = res.last0;
      end
      if (res.valid1 && (2'(base + 2'd1) == 2'(i))) begin
        q_word_next[i] = res.word1;
        q_last_next[i] = res.last1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_word[i] <= q_word_next[i];
      q_last[i] <= q_last_next[i];
    end
  end

endmodule
`default_nettype wire
